// ===== hdl/assert_macros.svh =====
// Assertion macros for the verification module of the window table.
// Depends on nothing; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window table check failed");

`endif

// ===== hdl/wthit_pkg.sv =====
// Types and constants for the window table hit-test block.
// Depends on nothing; imported by the top level.
package wthit_pkg;

    localparam int MAX_WINDOWS_DEF = 16;

    // Request codes.
    localparam logic [2:0] REQ_NEW   = 3'd0;
    localparam logic [2:0] REQ_CLOSE = 3'd1;
    localparam logic [2:0] REQ_DIRTY = 3'd2;
    localparam logic [2:0] REQ_HIT   = 3'd3;
    localparam logic [2:0] REQ_FOCUS = 3'd4;

    // Register indexes and reset values.
    localparam logic       REG_TITLE = 1'b0;
    localparam logic       REG_CLOSE = 1'b1;
    localparam logic [6:0] TITLE_RST = 7'd20;
    localparam logic [5:0] CLOSE_RST = 6'd14;

    // Close button inset from the window top and right edge.
    localparam logic signed [18:0] CLOSE_INSET = 19'sd3;
    localparam logic signed [18:0] DMG_Y_MAX   = 19'sd65535;

    // One table entry as stored in the memory.
    typedef struct packed {
        logic [15:0]        id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [12:0]        w;
        logic [12:0]        h;
        logic [31:0]        z;
    } t_entry;

endpackage

// ===== hdl/window_table_hit_test.sv =====
// Top level of the window table hit-test block: table memory and sequencer.
// Depends on wthit_pkg.
//
// Usage: a request item is taken when start is high and busy is low. It
// carries a request type, a window id, a position and a size. Exactly one
// result item follows on the o_ ports, marked by o_done for one cycle; the
// receiver takes it in that cycle and cannot stall it.
// The table lives in a single memory with one write port and one registered
// read port. Every request scans the live entries, each in an address state
// (S_RD) and then a compare state (S_CHK), and then passes S_ACT and S_DMG.
// A new window is written in the extra state S_NEW, and a removal that moves
// the last entry into the freed slot passes S_LRD and S_LWT first.
// busy stays high from the accepting edge and is low again when o_done is shown.
// Reset (synchronous, active low) empties the table, clears the raise
// counter and restores title_height 20 and close_size 14. The memory needs
// no clearing since only entries below the window count are ever read.
// The user writes registers over the APB port only while idle; the block does not enforce it.
module window_table_hit_test
    import wthit_pkg::*;
#(
    parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_req_type,
    input  logic [15:0]        i_win_id,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [12:0]        i_size_w,
    input  logic [12:0]        i_size_h,
    output logic               o_done,
    output logic               o_ok,
    output logic signed [16:0] o_damage_x,
    output logic signed [16:0] o_damage_y,
    output logic [16:0]        o_damage_w,
    output logic [16:0]        o_damage_h,
    output logic               o_hit_found,
    output logic [15:0]        o_hit_id,
    output logic               o_hit_in_title,
    output logic               o_hit_in_close
);

    localparam int AW = $clog2(MAX_WINDOWS);
    localparam int CW = $clog2(MAX_WINDOWS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_ACT  = 3'd3;
    localparam logic [2:0] S_LRD  = 3'd4;
    localparam logic [2:0] S_LWT  = 3'd5;
    localparam logic [2:0] S_NEW  = 3'd6;
    localparam logic [2:0] S_DMG  = 3'd7;

    t_entry r_mem [MAX_WINDOWS];
    t_entry r_rdata;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_count, n_count;
    logic [31:0]        r_raise, n_raise;
    logic [6:0]         r_title;
    logic [5:0]         r_close;
    logic [2:0]         r_type;
    logic [15:0]        r_id;
    logic signed [15:0] r_px, r_py;
    logic [12:0]        r_sw, r_sh;
    logic               r_found, n_found;
    logic [AW-1:0]      r_slot, n_slot;
    t_entry             r_m, n_m;
    logic               r_hit, n_hit;
    t_entry             r_top, n_top;
    logic               r_okf, n_okf;

    logic               we;
    logic [AW-1:0]      waddr;
    t_entry             wdata;
    logic [CW-1:0]      last;

    // APB register port; pready is always high.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CLOSE) ? {26'd0, r_close} : {25'd0, r_title};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_title <= TITLE_RST;
            r_close <= CLOSE_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_TITLE) begin
                r_title <= pwdata[6:0];
            end else begin
                r_close <= pwdata[5:0];
            end
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[r_idx[AW-1:0]];
    end

    assign busy = (r_state != S_IDLE);
    assign last = r_count - CW'(1);

    // Scan compare on the entry just read.
    logic signed [18:0] e_x, e_y, e_x1, e_y1, q_px, q_py;
    logic               e_in;
    always_comb begin
        q_px = {{3{r_px[15]}}, r_px};
        q_py = {{3{r_py[15]}}, r_py};
        e_x  = {{3{r_rdata.x[15]}}, r_rdata.x};
        e_y  = {{3{r_rdata.y[15]}}, r_rdata.y};
        e_x1 = e_x + $signed({6'd0, r_rdata.w});
        e_y1 = e_y + $signed({6'd0, r_rdata.h}) + $signed({12'd0, r_title});
        e_in = (q_px >= e_x) && (q_py >= e_y) && (q_px < e_x1) && (q_py < e_y1);
    end

    // Sequencer and memory write control.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_count = r_count;
        n_raise = r_raise;
        n_found = r_found;
        n_slot  = r_slot;
        n_m     = r_m;
        n_hit   = r_hit;
        n_top   = r_top;
        n_okf   = r_okf;
        we      = 1'b0;
        waddr   = r_slot;
        wdata   = r_rdata;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_hit   = 1'b0;
                    n_okf   = 1'b0;
                    n_state = (r_count == '0) ? S_ACT : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!r_found && r_rdata.id == r_id) begin
                    n_found = 1'b1;
                    n_slot  = r_idx[AW-1:0];
                    n_m     = r_rdata;
                end
                if (e_in && (!r_hit || r_rdata.z >= r_top.z)) begin
                    n_hit = 1'b1;
                    n_top = r_rdata;
                end
                n_idx   = r_idx + CW'(1);
                n_state = (n_idx == r_count) ? S_ACT : S_RD;
            end
            S_ACT: begin
                n_state = S_DMG;
                case (r_type)
                    REQ_NEW, REQ_CLOSE: begin
                        if (r_found) begin
                            n_okf = 1'b1;
                            if (CW'(r_slot) != last) begin
                                n_idx   = last;
                                n_state = S_LRD;
                            end else begin
                                n_count = last;
                                n_state = (r_type == REQ_NEW) ? S_NEW : S_DMG;
                            end
                        end else if (r_type == REQ_NEW && r_count < CW'(MAX_WINDOWS)) begin
                            n_okf   = 1'b1;
                            n_state = S_NEW;
                        end
                    end
                    REQ_DIRTY: begin
                        n_okf = r_found && (r_sw != '0) && (r_sh != '0);
                    end
                    REQ_HIT: begin
                        n_okf = 1'b1;
                    end
                    REQ_FOCUS: begin
                        if (r_found) begin
                            n_okf   = 1'b1;
                            n_raise = r_raise + 32'd1;
                            we      = 1'b1;
                            waddr   = r_slot;
                            wdata   = r_m;
                            wdata.z = n_raise;
                        end
                    end
                    default: begin
                        n_okf = 1'b0;
                    end
                endcase
            end
            S_LRD: begin
                n_state = S_LWT;
            end
            S_LWT: begin
                // Move the last entry into the freed slot.
                we      = 1'b1;
                waddr   = r_slot;
                wdata   = r_rdata;
                n_count = last;
                n_state = (r_type == REQ_NEW) ? S_NEW : S_DMG;
            end
            S_NEW: begin
                we      = 1'b1;
                waddr   = r_count[AW-1:0];
                wdata   = '{id: r_id, x: r_px, y: r_py, w: r_sw, h: r_sh,
                            z: {16'd0, r_id}};
                n_count = r_count + CW'(1);
                n_state = S_DMG;
            end
            S_DMG: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_raise <= '0;
            r_found <= 1'b0;
            r_hit   <= 1'b0;
            r_okf   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_raise <= n_raise;
            r_found <= n_found;
            r_hit   <= n_hit;
            r_okf   <= n_okf;
            r_idx   <= n_idx;
        end
    end

    // Request latch and scan results; payload only.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_type <= i_req_type;
            r_id   <= i_win_id;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_sw   <= i_size_w;
            r_sh   <= i_size_h;
        end
        r_slot <= n_slot;
        r_m    <= n_m;
        r_top  <= n_top;
    end

    // Damage and hit answer for the finished request.
    logic signed [18:0] nx, ny, nw, nh, ox, oy, ow, oh;
    logic signed [18:0] ux0, uy0, ux1, uy1, dx, dy, dw, dh, sy;
    logic signed [18:0] tx, ty, tw, cx, cy, cs, th;
    logic               new_ok, old_ok, f_title, f_close;
    always_comb begin
        th  = $signed({12'd0, r_title});
        cs  = $signed({13'd0, r_close});
        nx  = q_px;
        ny  = q_py;
        nw  = $signed({6'd0, r_sw});
        nh  = $signed({6'd0, r_sh}) + th;
        ox  = {{3{r_m.x[15]}}, r_m.x};
        oy  = {{3{r_m.y[15]}}, r_m.y};
        ow  = $signed({6'd0, r_m.w});
        oh  = $signed({6'd0, r_m.h}) + th;
        new_ok = (nw > 0) && (nh > 0);
        old_ok = r_found && (ow > 0) && (oh > 0);
        ux0 = (nx < ox) ? nx : ox;
        uy0 = (ny < oy) ? ny : oy;
        ux1 = (nx + nw > ox + ow) ? nx + nw : ox + ow;
        uy1 = (ny + nh > oy + oh) ? ny + nh : oy + oh;
        sy  = oy + th + q_py;
        dx = '0;
        dy = '0;
        dw = '0;
        dh = '0;
        if (r_okf) begin
            case (r_type)
                REQ_NEW: begin
                    if (new_ok && old_ok) begin
                        dx = ux0;
                        dy = uy0;
                        dw = ux1 - ux0;
                        dh = uy1 - uy0;
                    end else if (new_ok) begin
                        dx = nx;
                        dy = ny;
                        dw = nw;
                        dh = nh;
                    end else if (old_ok) begin
                        dx = ox;
                        dy = oy;
                        dw = ow;
                        dh = oh;
                    end
                end
                REQ_CLOSE: begin
                    dx = ox;
                    dy = oy;
                    dw = ow;
                    dh = oh;
                end
                REQ_DIRTY: begin
                    dx = ox + q_px;
                    dy = (sy > DMG_Y_MAX) ? DMG_Y_MAX : sy;
                    dw = nw;
                    dh = $signed({6'd0, r_sh});
                end
                default: begin
                    dx = '0;
                end
            endcase
        end
        // Title bar and close button of the top window.
        tx = {{3{r_top.x[15]}}, r_top.x};
        ty = {{3{r_top.y[15]}}, r_top.y};
        tw = $signed({6'd0, r_top.w});
        cx = tx + tw - cs - CLOSE_INSET;
        cy = ty + CLOSE_INSET;
        f_title = (q_px >= tx) && (q_py >= ty) && (q_px < tx + tw) && (q_py < ty + th);
        f_close = (q_px >= cx) && (q_py >= cy) && (q_px < cx + cs) && (q_py < cy + cs);
    end

    // Result registers; o_done marks the one cycle a result is shown.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= (r_state == S_DMG);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DMG) begin
            o_ok           <= r_okf;
            o_damage_x     <= dx[16:0];
            o_damage_y     <= dy[16:0];
            o_damage_w     <= dw[16:0];
            o_damage_h     <= dh[16:0];
            o_hit_found    <= (r_type == REQ_HIT) && r_hit;
            o_hit_id       <= ((r_type == REQ_HIT) && r_hit) ? r_top.id : 16'd0;
            o_hit_in_title <= (r_type == REQ_HIT) && r_hit && f_title;
            o_hit_in_close <= (r_type == REQ_HIT) && r_hit && f_close;
        end
    end

endmodule

// ===== hdl/wthit_chk.sv =====
// Port-level checker for the window table hit-test block, with its bind.
// Depends on assert_macros.svh; attaches to window_table_hit_test.
`include "assert_macros.svh"

module wthit_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic o_ok,
    input logic o_hit_found,
    input logic o_hit_in_title,
    input logic o_hit_in_close
);

    // An accepted item makes the block busy on the next cycle.
    `AST_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // A result is shown for a single cycle.
    `AST_NXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    // A result is shown only once the block has gone idle.
    `AST_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    // A hit, or a title or close flag, comes only with a successful request and a hit.
    `AST_IMP(a_hit_ok, i_clk, i_rst_n, o_done && (o_hit_found || o_hit_in_title || o_hit_in_close), o_ok && o_hit_found)

endmodule

bind window_table_hit_test wthit_chk u_wthit_chk (.*);
